/* design/fvn_pkg.sv */
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared types, widths and constants for the fractal value noise block.
// ----------------------------------------------------------------------------
package fvn_pkg;

    localparam int unsigned MAX_OCTAVES_DEF     = 8;
    localparam int unsigned COORD_FRAC_BITS_DEF = 14;

    localparam int unsigned COORD_W  = 24;
    localparam int unsigned NOISE_W  = 18;
    localparam int unsigned CORNER_W = 25;
    localparam int unsigned AMP_W    = 17;
    localparam int unsigned WEIGHT_W = CORNER_W + AMP_W + 1;
    localparam int unsigned PADDR_W  = 4;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [NOISE_W-1:0]  noise_t;
    typedef logic        [AMP_W-1:0]    amp_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;

    localparam logic [31:0] HASH_C1   = 32'h9E37_79B9;
    localparam logic [31:0] HASH_C2   = 32'h85EB_CA6B;
    localparam logic [31:0] HASH_C3   = 32'h7FEB_352D;
    localparam logic [31:0] HASH_C4   = 32'h846C_A68B;
    localparam logic [31:0] SEED_STEP = 32'd1013;

    typedef enum logic [1:0] {
        REG_BASE_SEED    = 2'd0,
        REG_OCTAVE_COUNT = 2'd1,
        REG_PERSISTENCE  = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    localparam logic [31:0] BASE_SEED_RST    = 32'd0;
    localparam logic [3:0]  OCTAVE_COUNT_RST = 4'd4;
    localparam logic [15:0] PERSISTENCE_RST  = 16'h8000;

endpackage

/* design/fvn_sample_if.sv */
// ----------------------------------------------------------------------------
// fvn_sample_if
// Coordinate request channel: valid/ready with an X/Z coordinate pair.
// ----------------------------------------------------------------------------
interface fvn_sample_if;
    logic            valid;
    logic            ready;
    fvn_pkg::coord_t x_coord;
    fvn_pkg::coord_t z_coord;

    modport source (output valid, output x_coord, output z_coord, input ready);
    modport sink   (input valid, input x_coord, input z_coord, output ready);
endinterface

/* design/fvn_result_if.sv */
// ----------------------------------------------------------------------------
// fvn_result_if
// Noise result channel: valid/ready with one normalised noise value.
// ----------------------------------------------------------------------------
interface fvn_result_if;
    logic            valid;
    logic            ready;
    fvn_pkg::noise_t noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

/* design/fractal_value_noise.sv */
// ----------------------------------------------------------------------------
// fractal_value_noise
// Fractal value noise over a Q10.14 coordinate pair, normalised to Q2.16.
// ----------------------------------------------------------------------------
// Pipeline: input register, octave stages, sum tree and normalise registers;
//   all octaves run side by side in their own pipelines.
// Throughput: one request per cycle while the sequencer is idle; a stalled
//   result holds the whole pipe.
// Reset: loads control and config reset values, then the amplitude/reciprocal
//   pass runs with ready low, as after a write of octave_count or persistence.
module fractal_value_noise #(
    parameter int unsigned MAX_OCTAVES     = fvn_pkg::MAX_OCTAVES_DEF,
    parameter int unsigned COORD_FRAC_BITS = fvn_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fvn_sample_if.sink                  sample,
    fvn_result_if.source                result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fvn_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int unsigned K_W   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int unsigned LAT   = 13;
    localparam int unsigned TOT_W = 46;

    // ---------------- configuration ----------------
    logic [31:0] base_seed_reg;
    logic [3:0]  octave_count_reg;
    logic [15:0] persistence_reg;
    logic        cfg_we;
    fvn_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = fvn_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_seed_reg    <= fvn_pkg::BASE_SEED_RST;
            octave_count_reg <= fvn_pkg::OCTAVE_COUNT_RST;
            persistence_reg  <= fvn_pkg::PERSISTENCE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                fvn_pkg::REG_BASE_SEED:    base_seed_reg    <= pwdata;
                fvn_pkg::REG_OCTAVE_COUNT: octave_count_reg <= pwdata[3:0];
                fvn_pkg::REG_PERSISTENCE:  persistence_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            fvn_pkg::REG_BASE_SEED:    prdata = base_seed_reg;
            fvn_pkg::REG_OCTAVE_COUNT: prdata = {28'd0, octave_count_reg};
            fvn_pkg::REG_PERSISTENCE:  prdata = {16'd0, persistence_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    logic [3:0] n_eff;
    always_comb
    begin
        priority if (octave_count_reg == 4'd0)
            n_eff = 4'd1;
        else if (32'(octave_count_reg) > MAX_OCTAVES)
            n_eff = 4'(MAX_OCTAVES);
        else
            n_eff = octave_count_reg;
    end

    // ---------------- amplitude / reciprocal sequencer ----------------
    typedef enum logic [2:0] {
        SEQ_IDLE = 3'b001,
        SEQ_AMP  = 3'b010,
        SEQ_DIV  = 3'b100
    } seq_state_t;

    seq_state_t         state_reg, state_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [5:0]         div_cnt_reg, div_cnt_next;
    fvn_pkg::amp_t      amp_cur_reg, amp_cur_next;
    logic [19:0]        sum_reg, sum_next;
    logic [19:0]        rem_reg, rem_next;
    logic [31:0]        quo_reg, quo_next;
    logic [31:0]        recip_reg, recip_next;
    fvn_pkg::amp_t      amp_reg [MAX_OCTAVES];
    logic               amp_we;
    fvn_pkg::amp_t      amp_wdata;
    logic [20:0]        trial;
    logic               restart;
    logic [32:0]        amp_prod;

    assign restart = cfg_we && (cfg_idx == fvn_pkg::REG_OCTAVE_COUNT
                                || cfg_idx == fvn_pkg::REG_PERSISTENCE);

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        div_cnt_next = div_cnt_reg;
        amp_cur_next = amp_cur_reg;
        sum_next     = sum_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        recip_next   = recip_reg;
        amp_we       = 1'b0;
        amp_wdata    = '0;
        amp_prod     = 33'(amp_cur_reg) * 33'(persistence_reg);
        trial        = {rem_reg, div_cnt_reg == 6'd47};
        unique case (state_reg)
            SEQ_IDLE: ;
            SEQ_AMP:
            begin
                amp_we       = 1'b1;
                amp_cur_next = fvn_pkg::AMP_W'(amp_prod >> 16);
                if (5'(k_reg) < 5'(n_eff))
                begin
                    amp_wdata = amp_cur_reg;
                    sum_next  = sum_reg + 20'(amp_cur_reg);
                end
                if (32'(k_reg) == MAX_OCTAVES - 1)
                begin
                    state_next   = SEQ_DIV;
                    div_cnt_next = 6'd47;
                    rem_next     = '0;
                    quo_next     = '0;
                end
                else
                    k_next = k_reg + K_W'(1);
            end
            SEQ_DIV:
            begin
                if (trial >= {1'b0, sum_reg})
                begin
                    rem_next = 20'(trial - {1'b0, sum_reg});
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[19:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - 6'd1;
                if (div_cnt_reg == 6'd0)
                begin
                    recip_next = quo_next;
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
        if (restart)
        begin
            state_next   = SEQ_AMP;
            k_next       = '0;
            amp_cur_next = fvn_pkg::AMP_W'(65536);
            sum_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SEQ_AMP;
            k_reg       <= '0;
            div_cnt_reg <= '0;
            amp_cur_reg <= fvn_pkg::AMP_W'(65536);
            sum_reg     <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            recip_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            div_cnt_reg <= div_cnt_next;
            amp_cur_reg <= amp_cur_next;
            sum_reg     <= sum_next;
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            recip_reg   <= recip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (amp_we)
            amp_reg[k_reg] <= amp_wdata;
    end

    // ---------------- datapath ----------------
    logic               seq_idle, adv, accept;
    logic [LAT-1:0]     vld_reg;
    fvn_pkg::coord_t    x_reg, z_reg;

    assign seq_idle     = (state_reg == SEQ_IDLE);
    assign adv          = !vld_reg[LAT-1] || result.ready;
    assign sample.ready = adv && seq_idle;
    assign accept       = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], accept};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= sample.x_coord;
            z_reg <= sample.z_coord;
        end
    end

    logic signed [TOT_W-1:0] term [8];

    for (genvar k = 0; k < 8; k++)
    begin : g_oct
        if (k < MAX_OCTAVES)
        begin : g_on
            fvn_pkg::weight_t wt;
            fvn_octave #(
                .OCT             (k),
                .COORD_FRAC_BITS (COORD_FRAC_BITS)
            ) u_octave (
                .clk       (clk),
                .en        (adv),
                .x_coord   (x_reg),
                .z_coord   (z_reg),
                .base_seed (base_seed_reg),
                .amp       (amp_reg[k]),
                .weighted  (wt)
            );
            assign term[k] = TOT_W'(wt);
        end
        else
        begin : g_off
            assign term[k] = '0;
        end
    end

    logic signed [TOT_W-1:0] sum1_reg [4];
    logic signed [TOT_W-1:0] sum2_reg [2];
    logic signed [TOT_W-1:0] total_reg;
    logic signed [TOT_W-17:0] norm;
    logic signed [63:0]      prod_reg, rnd;
    fvn_pkg::noise_t         noise_reg, noise_next;

    assign norm = (TOT_W-16)'(total_reg >>> 16);
    assign rnd  = (prod_reg + (64'sd1 <<< 37)) >>> 38;

    always_comb
    begin
        priority if (rnd > 64'sd65536)
            noise_next = fvn_pkg::NOISE_W'(65536);
        else if (rnd < -64'sd65536)
            noise_next = fvn_pkg::NOISE_W'(-65536);
        else
            noise_next = fvn_pkg::NOISE_W'(rnd);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                sum1_reg[i] <= term[2*i] + term[2*i+1];
            sum2_reg[0] <= sum1_reg[0] + sum1_reg[1];
            sum2_reg[1] <= sum1_reg[2] + sum1_reg[3];
            total_reg   <= sum2_reg[0] + sum2_reg[1];
            prod_reg    <= 64'(norm) * 64'($signed({1'b0, recip_reg}));
            noise_reg   <= noise_next;
        end
    end

    assign result.valid       = vld_reg[LAT-1];
    assign result.noise_value = noise_reg;

    // ---------------- assertions ----------------
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !seq_idle |-> !sample.ready)
        else $error("request taken during reciprocal pass");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (state_reg == SEQ_AMP))
        else $error("config write did not restart sequencer");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.noise_value <= 18'sd65536
                          && result.noise_value >= -18'sd65536))
        else $error("noise out of range");

    a_recip: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(seq_idle) |-> (recip_reg <= 32'h8000_0000 && recip_reg != 32'd0))
        else $error("reciprocal out of range");

endmodule

/* design/fvn_octave.sv */
// ----------------------------------------------------------------------------
// fvn_octave
// One noise octave: lattice hashing, quintic fade, bilinear blend and
// amplitude weighting, seven register stages advancing on en.
// ----------------------------------------------------------------------------
module fvn_octave #(
    parameter int unsigned OCT             = 0,
    parameter int unsigned COORD_FRAC_BITS = fvn_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             en,
    input  fvn_pkg::coord_t  x_coord,
    input  fvn_pkg::coord_t  z_coord,
    input  logic [31:0]      base_seed,
    input  fvn_pkg::amp_t    amp,
    output fvn_pkg::weight_t weighted
);

    localparam logic [31:0] FRAC_MASK = (32'd1 << COORD_FRAC_BITS) - 32'd1;
    localparam logic [31:0] SEED_OFS  = 32'(OCT) * fvn_pkg::SEED_STEP;

    localparam int unsigned CW = fvn_pkg::CORNER_W;

    logic signed [31:0] xs, zs;
    logic [31:0]        xi [2];
    logic [31:0]        zi [2];
    logic [15:0]        frac [2];

    assign xs = 32'(x_coord) <<< OCT;
    assign zs = 32'(z_coord) <<< OCT;
    assign xi[0] = xs >>> COORD_FRAC_BITS;
    assign zi[0] = zs >>> COORD_FRAC_BITS;
    assign xi[1] = xi[0] + 32'd1;
    assign zi[1] = zi[0] + 32'd1;
    assign frac[0] = 16'((xs & FRAC_MASK) << (16 - COORD_FRAC_BITS));
    assign frac[1] = 16'((zs & FRAC_MASK) << (16 - COORD_FRAC_BITS));

    // stage 1: coordinate products and seed
    logic [31:0] px_reg [2];
    logic [31:0] pz_reg [2];
    logic [31:0] seed_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg[0] <= xi[0] * fvn_pkg::HASH_C1;
            px_reg[1] <= xi[1] * fvn_pkg::HASH_C1;
            pz_reg[0] <= zi[0] * fvn_pkg::HASH_C2;
            pz_reg[1] <= zi[1] * fvn_pkg::HASH_C2;
            seed_reg  <= base_seed + SEED_OFS;
        end
    end

    // fade per axis: index 0 is x, 1 is z
    logic [16:0] fw_reg  [2];
    logic [16:0] fwd_reg [2];
    logic [16:0] wz2_reg;

    for (genvar ax = 0; ax < 2; ax++)
    begin : g_fade
        logic [15:0]        ft_reg, t2_reg, t3_reg;
        logic signed [20:0] fb_reg, fb2_reg;
        logic signed [21:0] fa;
        logic signed [38:0] fp1;
        logic signed [20:0] fb_next;
        logic [15:0]        t2_next, t3_next;
        logic signed [37:0] fp3, fsh;
        logic [16:0]        fw_next;

        always_comb
        begin
            fa      = $signed({6'b0, frac[ax]}) * 22'sd6 - 22'sd983040;
            fp1     = 39'(fa) * 39'($signed({1'b0, frac[ax]}));
            fb_next = 21'((fp1 >>> 16) + 39'sd655360);
            t2_next = 16'(({16'b0, frac[ax]} * {16'b0, frac[ax]}) >> 16);
            t3_next = 16'(({16'b0, t2_reg} * {16'b0, ft_reg}) >> 16);
            fp3     = 38'($signed({1'b0, t3_reg})) * 38'(fb2_reg);
            fsh     = fp3 >>> 16;
            priority if (fsh < 38'sd0)
                fw_next = 17'd0;
            else if (fsh > 38'sd65536)
                fw_next = 17'd65536;
            else
                fw_next = 17'(fsh);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ft_reg      <= frac[ax];
                fb_reg      <= fb_next;
                t2_reg      <= t2_next;
                t3_reg      <= t3_next;
                fb2_reg     <= fb_reg;
                fw_reg[ax]  <= fw_next;
                fwd_reg[ax] <= fw_reg[ax];
            end
        end
    end

    // corners: bit 0 picks x0/x1, bit 1 picks z0/z1
    logic signed [CW-1:0] corner_reg [4];

    for (genvar c = 0; c < 4; c++)
    begin : g_corner
        logic [31:0] h2_reg, h3_reg;
        logic [31:0] ha, hb, hc;

        always_comb
        begin
            ha = seed_reg ^ px_reg[c % 2];
            ha = {ha[18:0], ha[31:19]} ^ pz_reg[c / 2];
            ha = ha ^ (ha >> 16);
            hb = h2_reg ^ (h2_reg >> 15);
            hc = h3_reg ^ (h3_reg >> 16);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                h2_reg        <= ha * fvn_pkg::HASH_C3;
                h3_reg        <= hb * fvn_pkg::HASH_C4;
                corner_reg[c] <= $signed({1'b0, hc[23:0]}) - 25'sd8388607;
            end
        end
    end

    // blend and weighting
    logic signed [CW-1:0]  top_reg, bot_reg, val_reg;
    logic signed [43:0]    ptop, pbot, pv;
    logic signed [CW-1:0]  top_next, bot_next, val_next;
    fvn_pkg::weight_t      wt_reg;

    always_comb
    begin
        ptop     = 44'(corner_reg[1] - corner_reg[0])
                   * 44'($signed({1'b0, fwd_reg[0]}));
        pbot     = 44'(corner_reg[3] - corner_reg[2])
                   * 44'($signed({1'b0, fwd_reg[0]}));
        top_next = CW'(44'(corner_reg[0]) + (ptop >>> 16));
        bot_next = CW'(44'(corner_reg[2]) + (pbot >>> 16));
        pv       = 44'(bot_reg - top_reg) * 44'($signed({1'b0, wz2_reg}));
        val_next = CW'(44'(top_reg) + (pv >>> 16));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            wz2_reg <= fwd_reg[1];
            val_reg <= val_next;
            wt_reg  <= fvn_pkg::WEIGHT_W'(val_reg)
                       * fvn_pkg::WEIGHT_W'($signed({1'b0, amp}));
        end
    end

    assign weighted = wt_reg;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fractal_value_noise. Coordinate requests are driven
// with random gaps and the result side stalls at random, except in the last
// phase; every result is compared with a local bit-exact noise predictor. The
// register port is written between phases, with no requests in flight.
// ----------------------------------------------------------------------------
module testbench;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [fvn_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fvn_sample_if smp ();
    fvn_result_if res ();

    fractal_value_noise u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (smp),
        .result  (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the registers
    logic [31:0] seed_q;
    logic [3:0]  octaves_q;
    logic [15:0] persist_q;
    longint      recip_q;

    fvn_pkg::noise_t noise_queue[$];
    int          mismatches;
    int          checked;
    int          sent;
    bit          calm;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #20_000_000;
        $display("fractal_value_noise regression: fail");
        $finish;
    end

    function automatic int live_octaves();
        if (octaves_q == 4'd0)
            return 1;
        if (octaves_q > fvn_pkg::MAX_OCTAVES_DEF)
            return fvn_pkg::MAX_OCTAVES_DEF;
        return octaves_q;
    endfunction

    function automatic void refresh_recip();
        longint amp;
        longint total;
        amp = 65536;
        total = 0;
        for (int k = 0; k < live_octaves(); k++)
        begin
            total += amp;
            amp = (amp * persist_q) >>> 16;
        end
        recip_q = (longint'(1) <<< 47) / total;
    endfunction

    function automatic bit [31:0] lattice_hash(bit [31:0] xi, bit [31:0] zi, bit [31:0] seed);
        bit [31:0] h;
        h = seed ^ (xi * fvn_pkg::HASH_C1);
        h = {h[18:0], h[31:19]};
        h = h ^ (zi * fvn_pkg::HASH_C2);
        h = h ^ (h >> 16);
        h = h * fvn_pkg::HASH_C3;
        h = h ^ (h >> 15);
        h = h * fvn_pkg::HASH_C4;
        return h ^ (h >> 16);
    endfunction

    function automatic longint corner(bit [31:0] xi, bit [31:0] zi, bit [31:0] seed);
        bit [31:0] h;
        h = lattice_hash(xi, zi, seed);
        return longint'({8'd0, h[23:0]}) - 64'sh7FFFFF;
    endfunction

    function automatic longint quintic(longint t);
        longint a;
        longint b;
        longint t2;
        longint t3;
        longint f;
        a = 6 * t - 15 * 65536;
        b = ((t * a) >>> 16) + 10 * 65536;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        f = (t3 * b) >>> 16;
        if (f < 0)
            f = 0;
        if (f > 65536)
            f = 65536;
        return f;
    endfunction

    function automatic longint lerp(longint a, longint b, longint w);
        return a + (((b - a) * w) >>> 16);
    endfunction

    function automatic longint octave_value(longint x, longint z, bit [31:0] seed);
        longint    mask;
        bit [31:0] x0;
        bit [31:0] z0;
        longint    wx;
        longint    wz;
        longint    upper;
        longint    lower;
        mask = (longint'(1) <<< fvn_pkg::COORD_FRAC_BITS_DEF) - 1;
        x0 = 32'(x >>> fvn_pkg::COORD_FRAC_BITS_DEF);
        z0 = 32'(z >>> fvn_pkg::COORD_FRAC_BITS_DEF);
        wx = quintic((x & mask) <<< (16 - fvn_pkg::COORD_FRAC_BITS_DEF));
        wz = quintic((z & mask) <<< (16 - fvn_pkg::COORD_FRAC_BITS_DEF));
        upper = lerp(corner(x0, z0, seed), corner(x0 + 1, z0, seed), wx);
        lower = lerp(corner(x0, z0 + 1, seed), corner(x0 + 1, z0 + 1, seed), wx);
        return lerp(upper, lower, wz);
    endfunction

    function automatic fvn_pkg::noise_t predict_noise(fvn_pkg::coord_t xc,
                                                      fvn_pkg::coord_t zc);
        longint x;
        longint z;
        longint amp;
        longint total;
        longint n;
        longint r;
        x = xc;
        z = zc;
        amp = 65536;
        total = 0;
        for (int k = 0; k < live_octaves(); k++)
        begin
            total += octave_value(x <<< k, z <<< k,
                                  seed_q + 32'(k) * fvn_pkg::SEED_STEP) * amp;
            amp = (amp * persist_q) >>> 16;
        end
        n = total >>> 16;
        r = (n * recip_q + (longint'(1) <<< 37)) >>> 38;
        if (r > 65536)
            r = 65536;
        if (r < -65536)
            r = -65536;
        return fvn_pkg::noise_t'(r);
    endfunction

    task automatic reg_write(fvn_pkg::reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = fvn_pkg::PADDR_W'(idx) << 2;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            fvn_pkg::REG_BASE_SEED:
                seed_q = value;
            fvn_pkg::REG_OCTAVE_COUNT:
            begin
                octaves_q = value[3:0];
                refresh_recip();
            end
            fvn_pkg::REG_PERSISTENCE:
            begin
                persist_q = value[15:0];
                refresh_recip();
            end
            default: ;
        endcase
    endtask

    task automatic drain();
        while (noise_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // called at a falling edge; leaves valid high with the new request
    task automatic send_request(fvn_pkg::coord_t xc, fvn_pkg::coord_t zc);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            smp.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        smp.valid = 1'b1;
        smp.x_coord = xc;
        smp.z_coord = zc;
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
        noise_queue.push_back(predict_noise(xc, zc));
        sent++;
        @(negedge clk);
    endtask

    function automatic fvn_pkg::coord_t pick_coord();
        fvn_pkg::coord_t c;
        c = fvn_pkg::coord_t'($urandom);
        case ($urandom_range(0, 5))
            0: c[13:0] = 14'd0;
            1: c[13:0] = 14'h3FFF;
            2: c = fvn_pkg::coord_t'($urandom_range(0, 65535)) - 24'sd32768;
            3: c = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default: ;
        endcase
        return c;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (noise_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected noise result %0d", res.noise_value);
            end
            else
            begin
                fvn_pkg::noise_t want;
                want = noise_queue.pop_front();
                checked++;
                if (res.noise_value !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise mismatch: expected %0d actual %0d",
                                 want, res.noise_value);
                end
            end
        end
    end

    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                res.ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            res.ready = 1'b1;
        end
    end

    fvn_pkg::coord_t xs[16] = '{24'sd0, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF,
                                24'sd1, -24'sd1, 24'sd16383, 24'sd16384, -24'sd16384,
                                -24'sd1, 24'sd8192, 24'sd0, 24'sh400000, -24'sd16385,
                                24'sh555555};
    fvn_pkg::coord_t zs[16] = '{24'sd0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
                                -24'sd1, 24'sd1, 24'sd16383, 24'sd0, -24'sd16384,
                                -24'sd1, 24'sd8192, 24'sd16383, -24'sh400000, 24'sd16385,
                                24'shAAAAAA};

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        smp.valid = 1'b0;
        smp.x_coord = '0;
        smp.z_coord = '0;
        calm = 1'b0;
        mismatches = 0;
        checked = 0;
        sent = 0;
        seed_q = fvn_pkg::BASE_SEED_RST;
        octaves_q = fvn_pkg::OCTAVE_COUNT_RST;
        persist_q = fvn_pkg::PERSISTENCE_RST;
        refresh_recip();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < 16; i++)
            send_request(xs[i], zs[i]);

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase > 0)
            begin
                smp.valid = 1'b0;
                drain();
                case (phase)
                    1:
                    begin
                        reg_write(fvn_pkg::REG_BASE_SEED, 32'hFFFF_FFFF);
                        reg_write(fvn_pkg::REG_OCTAVE_COUNT, 32'd1);
                        reg_write(fvn_pkg::REG_PERSISTENCE, 32'd0);
                    end
                    2:
                    begin
                        reg_write(fvn_pkg::REG_BASE_SEED, $urandom);
                        reg_write(fvn_pkg::REG_OCTAVE_COUNT, 32'd8);
                        reg_write(fvn_pkg::REG_PERSISTENCE, 32'hFFFF);
                    end
                    3:
                    begin
                        reg_write(fvn_pkg::REG_OCTAVE_COUNT, 32'd0);
                        reg_write(fvn_pkg::REG_PERSISTENCE, $urandom_range(0, 65535));
                        reg_write(fvn_pkg::REG_UNUSED, $urandom);
                    end
                    4:
                    begin
                        reg_write(fvn_pkg::REG_OCTAVE_COUNT, 32'd15);
                        reg_write(fvn_pkg::REG_PERSISTENCE, 32'd1);
                    end
                    default:
                    begin
                        reg_write(fvn_pkg::REG_BASE_SEED, 32'd0);
                        reg_write(fvn_pkg::REG_OCTAVE_COUNT, $urandom_range(2, 7));
                        reg_write(fvn_pkg::REG_PERSISTENCE, 32'h8000);
                        calm = 1'b1;
                    end
                endcase
            end
            for (int i = 0; i < 315; i++)
            begin
                if (phase == 1 && i == 150)
                begin
                    smp.valid = 1'b0;
                    while (noise_queue.size() != 0)
                        @(negedge clk);
                end
                send_request(pick_coord(), pick_coord());
            end
        end
        smp.valid = 1'b0;
        drain();

        $display("sent %0d coordinate requests over six register settings, %0d results checked",
                 sent, checked);
        $display("octave counts 0..15 clamped, persistence 0 to 0xFFFF, lattice wrap covered");
        if (mismatches == 0)
            $display("fractal_value_noise regression: pass");
        else
            $display("fractal_value_noise regression: fail");
        $finish;
    end
endmodule

/* files.f */
design/fvn_pkg.sv
design/fvn_sample_if.sv
design/fvn_result_if.sv
design/fvn_octave.sv
design/fractal_value_noise.sv
verif/testbench.sv
